// ===== hw/rtl/prw_pkg.sv =====
// Package for the packet reorder window.
// Holds field widths, reset values, register indexes, opcodes, status codes and states.
// No dependencies.
package prw_pkg;

    localparam int SEQ_W    = 32;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_WINDOW_SLOTS = 64;

    localparam logic [SEQ_W-1:0] RESET_BASE_SEQ  = 32'd0;
    localparam logic [SEQ_W-1:0] RESET_HIGH_MARK = 32'd1000000;
    localparam logic [SEQ_W-1:0] RESET_LOW_MARK  = 32'd100000;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SEQ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK  = 2'd2;

    // Request opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OUTSIDE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_REFUSED = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } prw_state_t;

endpackage

// ===== hw/rtl/packet_reorder_window.sv =====
// Insert: one request per cycle unless the result register is held; the result is registered
//   and shows the cycle after accept. Flush: walk the window one slot per cycle, pausing on
//   each stored handle, which is read through the single read port of the handle memory and
//   then emitted. No request is taken while a flush runs.
// Reset: clears present bits, the wrap flag, config to defaults; the handle memory is not cleared.
// Top level of the packet reorder window; depends on prw_pkg.
module packet_reorder_window
    import prw_pkg::*;
#(
    parameter int WINDOW_SLOTS = DEF_WINDOW_SLOTS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 op,
    input  logic [SEQ_W-1:0]     seq,
    input  logic [HANDLE_W-1:0]  packet_handle,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic                 handle_valid,
    output logic [HANDLE_W-1:0]  packet_handle_res,
    output logic                 last,
    // configuration channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SEQ_W-1:0]     cfg_data
);

    localparam int IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    // Offsets at or above this are outside the window; the last slot is never used.
    localparam logic [SEQ_W-1:0] OFF_LIMIT = SEQ_W'(WINDOW_SLOTS - 1);

    // Configuration registers
    logic [SEQ_W-1:0] base_seq_reg, base_seq_next;
    logic [SEQ_W-1:0] high_mark_reg, high_mark_next;
    logic [SEQ_W-1:0] low_mark_reg, low_mark_next;

    // Control state
    prw_state_t              state_reg, state_next;
    logic [WINDOW_SLOTS-1:0] present_reg, present_next;
    logic                    wrap_flag_reg, wrap_flag_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    last_pend_reg, last_pend_next;

    // Result register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                hvalid_reg, hvalid_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic                last_reg, last_next;

    // Handle memory: one write port, one registered read port
    logic [HANDLE_W-1:0] slot_mem [WINDOW_SLOTS];
    logic [HANDLE_W-1:0] rd_data_reg;
    logic                mem_wr_en;
    logic [IDX_W-1:0]    mem_wr_idx;
    logic                mem_rd_en;

    logic                out_free;
    logic                in_accept;
    logic [SEQ_W-1:0]    offset;
    logic                raise_flag;
    logic                refuse;
    logic                in_window;
    logic [WINDOW_SLOTS-1:0] present_clr;

    // The result register is free when empty or being drained this cycle.
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Wrap guard and window offset for an insert
    assign raise_flag = !wrap_flag_reg && (seq > high_mark_reg);
    assign refuse     = wrap_flag_reg && (seq < low_mark_reg);
    assign offset     = seq - base_seq_reg;
    assign in_window  = offset < OFF_LIMIT;

    // Present bits with the scanned slot dropped; bits below idx are already clear,
    // so an all-zero vector marks the final handle of the flush.
    always_comb
    begin
        present_clr          = present_reg;
        present_clr[idx_reg] = 1'b0;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (op == OP_FLUSH) && (present_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (present_reg[idx_reg])
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last_pend_reg ? ST_IDLE : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        base_seq_next  = base_seq_reg;
        high_mark_next = high_mark_reg;
        low_mark_next  = low_mark_reg;
        present_next   = present_reg;
        wrap_flag_next = wrap_flag_reg;
        idx_next       = idx_reg;
        last_pend_next = last_pend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        hvalid_next    = hvalid_reg;
        handle_next    = handle_reg;
        last_next      = last_reg;
        mem_wr_en      = 1'b0;
        mem_wr_idx     = offset[IDX_W-1:0];
        mem_rd_en      = 1'b0;

        // Config writes land on every accepted write; unknown indexes drop silently.
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BASE_SEQ:  base_seq_next  = cfg_data;
                REG_HIGH_MARK: high_mark_next = cfg_data;
                REG_LOW_MARK:  low_mark_next  = cfg_data;
                default:       ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    hvalid_next    = 1'b0;
                    handle_next    = '0;
                    last_next      = 1'b1;
                    status_next    = STAT_OK;
                    idx_next       = '0;
                    if (op == OP_INSERT)
                    begin
                        out_valid_next = 1'b1;
                        if (refuse)
                        begin
                            wrap_flag_next = 1'b0;
                            status_next    = STAT_REFUSED;
                        end
                        else
                        begin
                            if (raise_flag)
                            begin
                                wrap_flag_next = 1'b1;
                            end
                            if (in_window)
                            begin
                                mem_wr_en                         = 1'b1;
                                present_next[offset[IDX_W-1:0]]   = 1'b1;
                            end
                            else
                            begin
                                status_next = STAT_OUTSIDE;
                            end
                        end
                    end
                    else if (present_reg == '0)
                    begin
                        // Empty flush: a single closing result
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (present_reg[idx_reg])
                begin
                    mem_rd_en      = 1'b1;
                    present_next   = present_clr;
                    last_pend_next = (present_clr == '0);
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STAT_OK;
                    hvalid_next    = 1'b1;
                    handle_next    = rd_data_reg;
                    last_next      = last_pend_reg;
                    idx_next       = idx_reg + 1'b1;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    // Control and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            present_reg   <= '0;
            wrap_flag_reg <= 1'b0;
            idx_reg       <= '0;
            last_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            base_seq_reg  <= RESET_BASE_SEQ;
            high_mark_reg <= RESET_HIGH_MARK;
            low_mark_reg  <= RESET_LOW_MARK;
        end
        else
        begin
            state_reg     <= state_next;
            present_reg   <= present_next;
            wrap_flag_reg <= wrap_flag_next;
            idx_reg       <= idx_next;
            last_pend_reg <= last_pend_next;
            out_valid_reg <= out_valid_next;
            base_seq_reg  <= base_seq_next;
            high_mark_reg <= high_mark_next;
            low_mark_reg  <= low_mark_next;
        end
    end

    // Result payload; qualified by out_valid_reg
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        hvalid_reg <= hvalid_next;
        handle_reg <= handle_next;
        last_reg   <= last_next;
    end

    // Handle memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            slot_mem[mem_wr_idx] <= packet_handle;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= slot_mem[idx_reg];
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign handle_valid      = hvalid_reg;
    assign packet_handle_res = handle_reg;
    assign last              = last_reg;

    // A scan always has at least one stored handle left to find.
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (present_reg != '0))
        else $error("scan running over an empty window");

    // Emitting the final handle returns to idle with the window empty.
    a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && last_pend_reg)
        |=> (state_reg == ST_IDLE && present_reg == '0 && out_valid && last))
        else $error("flush did not finish cleanly");

    // A refused insert clears the wrap flag and reports refusal.
    a_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && op == OP_INSERT && refuse)
        |=> (out_valid && status == STAT_REFUSED && !wrap_flag_reg))
        else $error("wrap refusal not reported");

    // A flushed handle without the closing mark only shows while the flush still runs.
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && handle_valid && !last) |-> (state_reg != ST_IDLE))
        else $error("intermediate flush result after the flush ended");

endmodule

// ===== tb/sv/packet_reorder_window_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for packet_reorder_window: directed and random requests,
// register settings, output stalls. Uses prw_pkg for widths, opcodes, status and
// register codes. Expected results come from a behavioral window predictor.
module packet_reorder_window_tb
    import prw_pkg::*;
();

    localparam int SLOTS = DEF_WINDOW_SLOTS;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PCT = 18;
    localparam int SINK_HOLD_CYCLES = 400;
    // Index past the register list; the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                handle_valid;
        logic [HANDLE_W-1:0] handle;
        logic                last;
    } window_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 op = OP_INSERT;
    logic [SEQ_W-1:0]     seq = '0;
    logic [HANDLE_W-1:0]  packet_handle = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic                 handle_valid;
    logic [HANDLE_W-1:0]  packet_handle_res;
    logic                 last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SEQ_W-1:0]     cfg_data = '0;

    // Predictor state: register copies, window contents and the wrap guard
    logic [SEQ_W-1:0]    cur_base = RESET_BASE_SEQ;
    logic [SEQ_W-1:0]    cur_high_mark = RESET_HIGH_MARK;
    logic [SEQ_W-1:0]    cur_low_mark = RESET_LOW_MARK;
    logic [HANDLE_W-1:0] slot_handle [SLOTS];
    logic                slot_taken [SLOTS];
    logic                wrap_armed = 1'b0;

    window_result_t window_results_due[$];

    // Shared knobs: no_gaps turns off idling on both sides; sink_hold_req asks the
    // receiver to hold off for that many cycles
    bit no_gaps = 1'b0;
    int sink_hold_req = 0;

    int error_count = 0;
    int cycle_count = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int flush_count = 0;
    int refused_count = 0;
    int outside_count = 0;
    int handles_flushed = 0;

    packet_reorder_window dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .op                (op),
        .seq               (seq),
        .packet_handle     (packet_handle),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .handle_valid      (handle_valid),
        .packet_handle_res (packet_handle_res),
        .last              (last),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, window_results_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_result(input logic [STATUS_W-1:0] st, input logic hv,
                               input logic [HANDLE_W-1:0] h, input logic lst);
        window_result_t r;
        r.status = st;
        r.handle_valid = hv;
        r.handle = h;
        r.last = lst;
        window_results_due.push_back(r);
    endtask

    // Advance the predicted window by one accepted request and queue what it emits
    task automatic predict_window_results(input logic req_op, input logic [SEQ_W-1:0] req_seq,
                                          input logic [HANDLE_W-1:0] req_handle);
        logic [SEQ_W-1:0] offset;
        int last_slot;
        if (req_op == OP_INSERT)
        begin
            // Wrap guard: raise above the high mark, or refuse and drop the flag below the low mark
            if (!wrap_armed && req_seq > cur_high_mark)
                wrap_armed = 1'b1;
            else if (wrap_armed && req_seq < cur_low_mark)
            begin
                wrap_armed = 1'b0;
                refused_count++;
                push_result(STAT_REFUSED, 1'b0, '0, 1'b1);
                return;
            end
            offset = req_seq - cur_base;
            // The top slot is never used
            if (offset < SEQ_W'(SLOTS - 1))
            begin
                slot_handle[offset] = req_handle;
                slot_taken[offset] = 1'b1;
                push_result(STAT_OK, 1'b0, '0, 1'b1);
            end
            else
            begin
                outside_count++;
                push_result(STAT_OUTSIDE, 1'b0, '0, 1'b1);
            end
        end
        else
        begin
            flush_count++;
            last_slot = -1;
            for (int i = 0; i < SLOTS; i++)
                if (slot_taken[i])
                    last_slot = i;
            // An empty window still answers with one closing result
            if (last_slot < 0)
                push_result(STAT_OK, 1'b0, '0, 1'b1);
            for (int i = 0; i <= last_slot; i++)
            begin
                if (slot_taken[i])
                begin
                    push_result(STAT_OK, 1'b1, slot_handle[i], i == last_slot);
                    slot_taken[i] = 1'b0;
                    handles_flushed++;
                end
            end
        end
    endtask

    // Offer one request: idle at random first, then hold valid and payload until accepted
    task automatic send_request(input logic req_op, input logic [SEQ_W-1:0] req_seq,
                                input logic [HANDLE_W-1:0] req_handle);
        @(negedge clk);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= req_op;
        seq <= req_seq;
        packet_handle <= req_handle;
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
        predict_window_results(req_op, req_seq, req_handle);
    endtask

    // Drop the request line, then hold until every predicted result has come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (window_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [SEQ_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_BASE_SEQ:  cur_base = value;
            REG_HIGH_MARK: cur_high_mark = value;
            REG_LOW_MARK:  cur_low_mark = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly in-window inserts with some flushes, probes around the wrap marks and
    // raw sequence numbers; optionally pause halfway until the window drains
    task automatic random_burst(input int count, input bit pause_midway);
        int pick;
        logic [SEQ_W-1:0] s;
        logic req_op;
        for (int k = 0; k < count; k++)
        begin
            if (pause_midway && k == count / 2)
                wait_drained();
            pick = $urandom_range(99);
            req_op = OP_INSERT;
            s = $urandom;
            if (pick < 12)
                req_op = OP_FLUSH;
            else if (pick < 72)
                s = cur_base + $urandom_range(SLOTS + 2);
            else if (pick < 82)
                s = ($urandom_range(1) ? cur_high_mark : cur_low_mark) + $urandom_range(2) - 1;
            send_request(req_op, s, $urandom);
        end
    endtask

    // Reset register values: empty flush, window edges, wrap guard raise and refusal,
    // overwrite, ordered flush
    task automatic test_directed_cases();
        send_request(OP_FLUSH, 32'h0, 32'h0);
        send_request(OP_INSERT, 32'd0, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'd62, 32'h0000_0000);
        send_request(OP_INSERT, 32'd63, 32'h1111_1111);
        send_request(OP_INSERT, 32'd64, 32'h2222_2222);
        send_request(OP_INSERT, RESET_HIGH_MARK, 32'h3333_3333);
        send_request(OP_INSERT, RESET_HIGH_MARK + 1, 32'h4444_4444);
        send_request(OP_INSERT, RESET_LOW_MARK, 32'h5555_5555);
        send_request(OP_INSERT, 32'd5, 32'h6666_6666);
        send_request(OP_INSERT, 32'd5, 32'hA5A5_A5A5);
        send_request(OP_INSERT, 32'd0, 32'h1234_5678);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h7777_7777);
        send_request(OP_INSERT, 32'd0, 32'h8888_8888);
        send_request(OP_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_FLUSH, 32'h0, 32'h0);
        wait_drained();
    endtask

    // Walk through register settings, extremes included, with a burst under each
    task automatic test_register_settings();
        random_burst(14, 1'b0);
        wait_drained();

        // Window straddles the sequence wrap; the flag can never rise
        write_register(REG_BASE_SEQ, 32'hFFFF_FFE0);
        write_register(REG_HIGH_MARK, 32'hFFFF_FFFF);
        write_register(REG_LOW_MARK, 32'h0000_0000);
        random_burst(14, 1'b0);
        wait_drained();

        // Any nonzero sequence raises the flag; run this stretch with no idling
        write_register(REG_BASE_SEQ, 32'h0000_0000);
        write_register(REG_HIGH_MARK, 32'h0000_0000);
        no_gaps = 1'b1;
        random_burst(14, 1'b0);
        wait_drained();
        no_gaps = 1'b0;

        // Raise and refuse nearly every other insert; pause midway until drained
        write_register(REG_BASE_SEQ, 32'h8000_0000);
        write_register(REG_LOW_MARK, 32'hFFFF_FFFF);
        random_burst(14, 1'b1);
        wait_drained();

        write_register(REG_BASE_SEQ, $urandom);
        write_register(REG_HIGH_MARK, $urandom);
        write_register(REG_LOW_MARK, $urandom);
        random_burst(14, 1'b0);
        wait_drained();

        // Write past the register list, then put the window across the high mark
        write_register(REG_UNUSED, $urandom);
        write_register(REG_BASE_SEQ, RESET_HIGH_MARK - 30);
        write_register(REG_HIGH_MARK, RESET_HIGH_MARK);
        write_register(REG_LOW_MARK, RESET_LOW_MARK);
        random_burst(14, 1'b0);
        wait_drained();
    endtask

    // Hold the result side for a long stretch while the full window is filled in
    // shuffled order and flushed; the block must stall its request side
    task automatic test_output_stall();
        int order [SLOTS - 1];
        int j;
        int tmp;
        for (int i = 0; i < SLOTS - 1; i++)
            order[i] = i;
        for (int i = SLOTS - 2; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        sink_hold_req = SINK_HOLD_CYCLES;
        for (int i = 0; i < SLOTS - 1; i++)
            send_request(OP_INSERT, cur_base + order[i], $urandom);
        send_request(OP_FLUSH, $urandom, $urandom);
        wait_drained();
    endtask

    // Result side: random stalls, or a long hold when asked, counted here
    initial
    begin : sink_driver
        int held;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_hold_req > 0)
            begin
                out_ready <= 1'b0;
                for (held = 1; held < sink_hold_req; held++)
                    @(negedge clk);
                sink_hold_req = 0;
            end
            else
                out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin : result_check
        window_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (window_results_due.size() == 0)
            begin
                $error("unexpected result: status %0d handle_valid %0d handle %h last %0d",
                       status, handle_valid, packet_handle_res, last);
                error_count++;
            end
            else
            begin
                want = window_results_due.pop_front();
                results_checked++;
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    error_count++;
                end
                if (handle_valid !== want.handle_valid)
                begin
                    $error("handle_valid: expected %0d, actual %0d",
                           want.handle_valid, handle_valid);
                    error_count++;
                end
                if (packet_handle_res !== want.handle)
                begin
                    $error("packet_handle_res: expected %h, actual %h",
                           want.handle, packet_handle_res);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_handle[i] = '0;
            slot_taken[i] = 1'b0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_register_settings();
        test_output_stall();

        // Wait on after draining to catch any stray result
        wait_drained();
        repeat (2 * SLOTS + 1) @(posedge clk);
        if (window_results_due.size() != 0)
        begin
            $error("%0d predicted results never arrived", window_results_due.size());
            error_count++;
        end

        $display("Ran %0d requests (%0d flushes, %0d wrap refusals, %0d outside window)",
                 requests_sent, flush_count, refused_count, outside_count);
        $display("Checked %0d results, %0d flushed handles, over six register settings",
                 results_checked, handles_flushed);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/prw_pkg.sv
hw/rtl/packet_reorder_window.sv
tb/sv/packet_reorder_window_tb.sv
